// ===== hdl/hpfc_pkg.sv =====
`default_nettype none

package hpfc_pkg;

  // stream payload widths
  localparam int unsigned HALF_W   = 16;
  localparam int unsigned WIDE_W   = 32;
  localparam int unsigned TDATA_W  = 48;
  localparam int unsigned TUSER_W  = 3;

  typedef enum logic {
    CMD_NARROW = 1'b0,
    CMD_WIDEN  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    FMT_B32  = 2'd0,
    FMT_B64  = 2'd1,
    FMT_X80  = 2'd2,
    FMT_B128 = 2'd3
  } wide_fmt_e;

  // class of a narrowing operand after exponent decode
  typedef enum logic [2:0] {
    NCLS_ZERO,
    NCLS_SPEC,
    NCLS_OVF,
    NCLS_SUB,
    NCLS_NORM
  } ncls_e;

  localparam logic [4:0]  HALF_EXP_MAX = 5'h1F;
  localparam logic [14:0] HALF_INF     = 15'h7C00;

  // decode stage
  typedef struct packed {
    cmd_e        cmd;
    wide_fmt_e   fmt;
    logic        sign;
    ncls_e       ncls;
    logic [23:0] sig;        // hidden bit at 23, rounding bit at 12
    logic [4:0]  hexp;       // binary16 exponent (narrow: rebiased, widen: input)
    logic [3:0]  sub_shift;  // extra right shift for binary16 subnormals
    logic        wzero;
    logic [9:0]  hfrac;
    logic [3:0]  norm_shift; // shifts to normalise a binary16 subnormal
  } s1_t;

  // shift stage
  typedef struct packed {
    cmd_e        cmd;
    wide_fmt_e   fmt;
    logic        sign;
    logic [14:0] nbase;
    logic        ninc;
    logic        wzero;
    logic [14:0] wexp;
    logic [9:0]  wfrac;
  } s2_t;

endpackage

`default_nettype wire

// ===== hdl/hpfc_core.sv =====
`default_nettype none

module hpfc_core (
  input  wire logic                         clk_i,
  input  wire logic [2:0]                   stage_en_i,
  input  wire logic [hpfc_pkg::TDATA_W-1:0] s_tdata_i,
  input  wire logic [hpfc_pkg::TUSER_W-1:0] s_tuser_i,
  output logic      [hpfc_pkg::TDATA_W-1:0] m_tdata_o
);
  import hpfc_pkg::*;

  function automatic logic [14:0] fmt_emax(input wide_fmt_e f);
    logic [14:0] r;
    unique case (f)
      FMT_B32:  r = 15'h00FF;
      FMT_B64:  r = 15'h07FF;
      FMT_X80:  r = 15'h7FFF;
      FMT_B128: r = 15'h7FFF;
      default:  r = 15'h7FFF;
    endcase
    return r;
  endfunction

  // bias minus the binary16 bias
  function automatic logic [14:0] fmt_rebias(input wide_fmt_e f);
    logic [14:0] r;
    unique case (f)
      FMT_B32:  r = 15'd112;
      FMT_B64:  r = 15'd1008;
      FMT_X80:  r = 15'd16368;
      FMT_B128: r = 15'd16368;
      default:  r = 15'd16368;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] lead_shift(input logic [9:0] f);
    logic [3:0] n;
    n = 4'd10;
    for (int i = 0; i < 10; i++) begin
      if (f[i]) n = 4'(10 - i);
    end
    return n;
  endfunction

  s1_t s1_d, s1_q;
  s2_t s2_d, s2_q;
  logic [TDATA_W-1:0] out_d, out_q;

  // stage 1: field decode, rebias, classify, leading-zero count
  logic [31:0]        wword;
  logic [15:0]        hword;
  logic [14:0]        nexp;
  logic signed [16:0] nhe;
  logic [16:0]        nhe_neg;

  always_comb begin
    wword = s_tdata_i[WIDE_W-1:0];
    hword = s_tdata_i[WIDE_W+HALF_W-1:WIDE_W];
    s1_d.cmd = cmd_e'(s_tuser_i[0]);
    s1_d.fmt = wide_fmt_e'(s_tuser_i[2:1]);
    unique case (s1_d.fmt)
      FMT_B32: begin
        nexp     = {7'b0, wword[30:23]};
        s1_d.sig = {1'b1, wword[22:0]};
      end
      FMT_B64: begin
        nexp     = {4'b0, wword[30:20]};
        s1_d.sig = {1'b1, wword[19:0], 3'b0};
      end
      FMT_X80: begin
        nexp     = wword[30:16];
        s1_d.sig = {1'b1, wword[14:0], 8'b0};
      end
      FMT_B128: begin
        nexp     = wword[30:16];
        s1_d.sig = {1'b1, wword[15:0], 7'b0};
      end
      default: begin
        nexp     = wword[30:16];
        s1_d.sig = {1'b1, wword[15:0], 7'b0};
      end
    endcase
    nhe     = $signed({2'b0, nexp} - {2'b0, fmt_rebias(s1_d.fmt)});
    nhe_neg = 17'(-nhe);
    s1_d.sub_shift = nhe_neg[3:0];
    priority if (nexp == 15'd0)              s1_d.ncls = NCLS_ZERO;
    else if (nexp == fmt_emax(s1_d.fmt))     s1_d.ncls = NCLS_SPEC;
    else if (nhe >= 17'sd31)                 s1_d.ncls = NCLS_OVF;
    else if (nhe < -17'sd10)                 s1_d.ncls = NCLS_ZERO;
    else if (nhe <= 17'sd0)                  s1_d.ncls = NCLS_SUB;
    else                                     s1_d.ncls = NCLS_NORM;
    s1_d.wzero      = (hword[14:0] == 15'd0);
    s1_d.hfrac      = hword[9:0];
    s1_d.norm_shift = lead_shift(hword[9:0]);
    if (s1_d.cmd == CMD_WIDEN) begin
      s1_d.sign = hword[15];
      s1_d.hexp = hword[14:10];
    end else begin
      s1_d.sign = wword[31];
      s1_d.hexp = nhe[4:0];
    end
  end

  // stage 2: narrowing result select with subnormal alignment, widening normalisation and exponent
  logic [10:0] sub_m;
  logic [10:0] wmant;

  always_comb begin
    s2_d.cmd   = s1_q.cmd;
    s2_d.fmt   = s1_q.fmt;
    s2_d.sign  = s1_q.sign;
    s2_d.wzero = s1_q.wzero;
    sub_m = 11'(s1_q.sig >> (5'd13 + {1'b0, s1_q.sub_shift}));
    unique case (s1_q.ncls)
      NCLS_ZERO: begin
        s2_d.nbase = 15'd0;
        s2_d.ninc  = 1'b0;
      end
      NCLS_SPEC: begin
        // nan keeps its top payload bits with the lowest forced on
        s2_d.nbase = (s1_q.sig[22:0] != 23'd0) ?
                     {HALF_EXP_MAX, s1_q.sig[22:14], 1'b1} : HALF_INF;
        s2_d.ninc  = 1'b0;
      end
      NCLS_OVF: begin
        s2_d.nbase = HALF_INF;
        s2_d.ninc  = 1'b0;
      end
      NCLS_SUB: begin
        s2_d.nbase = {5'b0, sub_m[10:1]};
        s2_d.ninc  = sub_m[0];
      end
      NCLS_NORM: begin
        s2_d.nbase = {s1_q.hexp, s1_q.sig[22:13]};
        s2_d.ninc  = s1_q.sig[12];
      end
      default: begin
        s2_d.nbase = 15'd0;
        s2_d.ninc  = 1'b0;
      end
    endcase
    wmant = {1'b0, s1_q.hfrac} << s1_q.norm_shift;
    if (s1_q.hexp == HALF_EXP_MAX) begin
      s2_d.wexp  = fmt_emax(s1_q.fmt);
      s2_d.wfrac = s1_q.hfrac;
    end else if (s1_q.hexp == 5'd0) begin
      s2_d.wexp  = fmt_rebias(s1_q.fmt) + 15'd1 - {11'b0, s1_q.norm_shift};
      s2_d.wfrac = wmant[9:0];
    end else begin
      s2_d.wexp  = fmt_rebias(s1_q.fmt) + {10'b0, s1_q.hexp};
      s2_d.wfrac = s1_q.hfrac;
    end
  end

  // stage 3: rounding increment and result assembly
  logic [14:0]       nmag;
  logic [HALF_W-1:0] half_res;
  logic [WIDE_W-1:0] wide_res;

  always_comb begin
    nmag = s2_q.nbase + {14'b0, s2_q.ninc};
    unique case (s2_q.fmt)
      FMT_B32:  wide_res = {s2_q.sign, s2_q.wexp[7:0], s2_q.wfrac, 13'b0};
      FMT_B64:  wide_res = {s2_q.sign, s2_q.wexp[10:0], s2_q.wfrac, 10'b0};
      FMT_X80:  wide_res = {s2_q.sign, s2_q.wexp, 1'b1, s2_q.wfrac, 5'b0};
      FMT_B128: wide_res = {s2_q.sign, s2_q.wexp, s2_q.wfrac, 6'b0};
      default:  wide_res = {s2_q.sign, s2_q.wexp, s2_q.wfrac, 6'b0};
    endcase
    if (s2_q.wzero) wide_res = {s2_q.sign, 31'b0};
    if (s2_q.cmd == CMD_WIDEN) begin
      half_res = '0;
    end else begin
      half_res = {s2_q.sign, nmag};
      wide_res = '0;
    end
    out_d = {wide_res, half_res};
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[0]) s1_q <= s1_d;
    if (stage_en_i[1]) s2_q <= s2_d;
    if (stage_en_i[2]) out_q <= out_d;
  end

  assign m_tdata_o = out_q;

endmodule

`default_nettype wire

// ===== hdl/half_precision_format_converter_top.sv =====
// channel | direction | tdata (low bit up)                    | tuser (low bit up)
// s_axis  | in        | wide_upper_word[31:0], half_word[47:32] | cmd[0], wide_format[2:1]
// m_axis  | out       | half_result[15:0], wide_result_upper[47:16] | -
//
// one transaction per cycle sustained while m_axis_tready stays high; three
// register stages (decode, shift, round/assemble) each carry their own valid bit
// ready ripples back stage by stage, so a held result stalls only the stages
// behind it and any empty stage still takes a new transaction
// reset clears the stage valid bits only; payload registers are not reset

`default_nettype none

module half_precision_format_converter_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // wide_upper_word [31:0], half_word [47:32]
  input  wire logic [hpfc_pkg::TDATA_W-1:0] s_axis_tdata,
  // cmd [0], wide_format [2:1]
  input  wire logic [hpfc_pkg::TUSER_W-1:0] s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // half_result [15:0], wide_result_upper [47:16]
  output logic      [hpfc_pkg::TDATA_W-1:0] m_axis_tdata
);
  import hpfc_pkg::*;

  // per-stage valid bits: decode, shift, output
  logic [2:0] vld_d, vld_q;
  // per-stage load enable, also the ready seen by the stage behind
  logic [2:0] stage_rdy;

  always_comb begin
    stage_rdy[2] = !vld_q[2] || m_axis_tready;
    stage_rdy[1] = !vld_q[1] || stage_rdy[2];
    stage_rdy[0] = !vld_q[0] || stage_rdy[1];
    vld_d = vld_q;
    if (stage_rdy[0]) vld_d[0] = s_axis_tvalid;
    if (stage_rdy[1]) vld_d[1] = vld_q[0];
    if (stage_rdy[2]) vld_d[2] = vld_q[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_axis_tready = stage_rdy[0];
  assign m_axis_tvalid = vld_q[2];

  // conversion datapath
  hpfc_core u_core (
    .clk_i      (clk_i),
    .stage_en_i (stage_rdy),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .m_tdata_o  (m_axis_tdata)
  );

  // an accepted transaction always lands in the decode stage
  a_in_to_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> vld_q[0])
    else $error("accepted transaction lost at decode stage");

  // a draining output never back-pressures the input
  a_drain_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output drains");

  // an empty output stage means no stall anywhere
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output stage");

  // a shift-stage item moves into an empty output stage
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[1] && !vld_q[2]) |=> vld_q[2])
    else $error("pipeline failed to advance into empty output stage");

  // only one of the two result fields is ever nonzero
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tdata[HALF_W-1:0] == '0 || m_axis_tdata[TDATA_W-1:HALF_W] == '0))
    else $error("both narrow and wide results populated");

endmodule

`default_nettype wire

// ===== dv/tb_half_precision_format_converter_top.sv =====
`default_nettype none

module tb_half_precision_format_converter_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hpfc_pkg::*;

  // one conversion request as carried on the slave side
  typedef struct {
    cmd_e        cmd;
    wide_fmt_e   fmt;
    logic [31:0] wide_word;
    logic [15:0] half_word;
  } conv_req_t;

  // one conversion result as carried on the master side
  typedef struct {
    logic [15:0] half;
    logic [31:0] wide;
  } conv_res_t;

  // layout of the upper word of each wide format
  typedef struct {
    int          drop;   // fraction bits beyond the ten that binary16 keeps
    int          shift;  // position of the exponent field
    logic [31:0] emax;   // all-ones exponent
    int          bias;
  } fmt_geom_t;

  class conversion_scoreboard;
    conv_res_t awaited[$];
    int        errors;

    function new();
      errors = 0;
    endfunction

    function fmt_geom_t geometry(wide_fmt_e fmt);
      fmt_geom_t g;
      case (fmt)
        FMT_B32: begin
          g.drop = 13; g.shift = 23; g.emax = 32'hFF; g.bias = 127;
        end
        FMT_B64: begin
          g.drop = 10; g.shift = 20; g.emax = 32'h7FF; g.bias = 1023;
        end
        FMT_X80: begin
          g.drop = 5; g.shift = 16; g.emax = 32'h7FFF; g.bias = 16383;
        end
        default: begin
          g.drop = 6; g.shift = 16; g.emax = 32'h7FFF; g.bias = 16383;
        end
      endcase
      return g;
    endfunction

    function logic [15:0] narrow_to_half(wide_fmt_e fmt, logic [31:0] w);
      fmt_geom_t   g;
      logic [31:0] hidden, sgn, e, f, m, h;
      int          he;
      g      = geometry(fmt);
      hidden = 32'd1 << (10 + g.drop);
      sgn    = (w >> 16) & 32'h8000;
      e      = (w >> g.shift) & g.emax;
      f      = w & (hidden - 1);
      // zero and wide subnormals flush to signed zero
      if (e == 0) return sgn[15:0];
      // infinity, or NaN with the low payload bit forced on
      if (e == g.emax) begin
        h = sgn | 32'h7C00 | ((f != 0) ? ((f >> g.drop) | 32'd1) : 32'd0);
        return h[15:0];
      end
      he = int'(e) + 15 - g.bias;
      if (he >= 31) begin
        h = sgn | 32'h7C00;
        return h[15:0];
      end
      if (he <= 0) begin
        if (he < -10) return sgn[15:0];
        m = (f | hidden) >> (g.drop - he);
        m = (m >> 1) + (m & 32'd1);
        h = sgn | m;
        return h[15:0];
      end
      // normal: round on the first dropped bit, carry may reach the exponent
      h = (32'(he) << 10) | (f >> g.drop);
      if (((f >> (g.drop - 1)) & 32'd1) != 0) h = h + 1;
      h = sgn | h;
      return h[15:0];
    endfunction

    function logic [31:0] widen_half(wide_fmt_e fmt, logic [15:0] hw);
      fmt_geom_t   g;
      logic [31:0] sgn, m, frac, res;
      int          e, n;
      g   = geometry(fmt);
      sgn = {hw[15], 31'b0};
      if (hw[14:0] == 15'd0) return sgn;
      if (hw[14:10] == 5'd31) begin
        e    = int'(g.emax);
        frac = {22'b0, hw[9:0]};
      end else if (hw[14:10] == 5'd0) begin
        // normalise a binary16 subnormal
        m = {22'b0, hw[9:0]};
        n = 0;
        while (m[10] == 1'b0 && n < 11) begin
          m = m << 1;
          n++;
        end
        e    = g.bias - 14 - n;
        frac = {22'b0, m[9:0]};
      end else begin
        e    = int'(hw[14:10]) + g.bias - 15;
        frac = {22'b0, hw[9:0]};
      end
      res = sgn | (32'(e) << g.shift) | (frac << g.drop);
      // explicit integer bit of the 80-bit format
      if (fmt == FMT_X80) res = res | 32'h8000;
      return res;
    endfunction

    function void note_input(conv_req_t req);
      conv_res_t r;
      if (req.cmd == CMD_NARROW) begin
        r.half = narrow_to_half(req.fmt, req.wide_word);
        r.wide = '0;
      end else begin
        r.half = '0;
        r.wide = widen_half(req.fmt, req.half_word);
      end
      awaited.push_back(r);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [47:0] data);
      conv_res_t r;
      if (awaited.size() == 0) begin
        report($sformatf("result %h with nothing awaited", data));
      end else begin
        r = awaited.pop_front();
        if (data[15:0] !== r.half)
          report($sformatf("half_result %h, awaited %h", data[15:0], r.half));
        if (data[47:16] !== r.wide)
          report($sformatf("wide_result_upper %h, awaited %h", data[47:16], r.wide));
      end
    endtask
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [TUSER_W-1:0]  s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]  m_axis_tdata;

  int src_idle_pct  = 0;
  int snk_stall_pct = 0;

  conversion_scoreboard sb = new();

  half_precision_format_converter_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // upper word from a biased exponent and the remaining bits
  function automatic logic [31:0] wide_word(wide_fmt_e fmt, bit sgn, logic [31:0] e,
                                            logic [31:0] rest);
    fmt_geom_t g;
    g = sb.geometry(fmt);
    return {sgn, 31'b0} | ((e & g.emax) << g.shift) | (rest & ((32'd1 << g.shift) - 1));
  endfunction

  // biased wide exponent that maps to a given binary16 exponent
  function automatic logic [31:0] exp_for(wide_fmt_e fmt, int he);
    fmt_geom_t g;
    g = sb.geometry(fmt);
    return 32'(he - 15 + g.bias);
  endfunction

  function automatic conv_req_t random_req();
    conv_req_t req;
    fmt_geom_t g;
    int        sel;
    logic [31:0] w, e;
    req.cmd       = cmd_e'($urandom_range(0, 1));
    req.fmt       = wide_fmt_e'($urandom_range(0, 3));
    req.half_word = 16'($urandom);
    g   = sb.geometry(req.fmt);
    sel = $urandom_range(0, 9);
    w   = $urandom;
    if (sel >= 2) begin
      // mostly steer the exponent near the binary16 range
      if (sel == 2) e = 32'd0;
      else if (sel == 3) e = g.emax;
      else e = exp_for(req.fmt, int'($urandom_range(0, 44)) - 12);
      w = (w & ~(g.emax << g.shift)) | (e << g.shift);
      if (sel <= 3 && $urandom_range(0, 2) == 0)
        w = w & ~((32'd1 << (10 + g.drop)) - 1);
    end
    req.wide_word = w;
    return req;
  endfunction

  task send(conv_req_t req);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {req.half_word, req.wide_word};
    s_axis_tuser  <= {req.fmt, req.cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(req);
  endtask

  task send_narrow(wide_fmt_e fmt, logic [31:0] w);
    conv_req_t req;
    req.cmd = CMD_NARROW; req.fmt = fmt; req.wide_word = w; req.half_word = 16'hA5A5;
    send(req);
  endtask

  task send_widen(wide_fmt_e fmt, logic [15:0] hw);
    conv_req_t req;
    req.cmd = CMD_WIDEN; req.fmt = fmt; req.wide_word = 32'h5A5A_5A5A; req.half_word = hw;
    send(req);
  endtask

  task drain();
    while (sb.awaited.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // narrowing corners
    send_narrow(FMT_B32,  wide_word(FMT_B32, 1'b0, 32'd0, 32'd0));
    send_narrow(FMT_B64,  wide_word(FMT_B64, 1'b1, 32'd0, 32'hFFFFF));
    send_narrow(FMT_X80,  wide_word(FMT_X80, 1'b0, 32'h7FFF, 32'h8000));
    send_narrow(FMT_B128, wide_word(FMT_B128, 1'b1, 32'h7FFF, 32'd0));
    send_narrow(FMT_B32,  wide_word(FMT_B32, 1'b0, 32'hFF, 32'h400000));
    send_narrow(FMT_B64,  wide_word(FMT_B64, 1'b0, 32'h7FF, 32'h1));
    send_narrow(FMT_X80,  wide_word(FMT_X80, 1'b0, exp_for(FMT_X80, 31), 32'h8000));
    send_narrow(FMT_B128, wide_word(FMT_B128, 1'b0, exp_for(FMT_B128, 30), 32'hFFC0));
    send_narrow(FMT_B32,  wide_word(FMT_B32, 1'b1, exp_for(FMT_B32, 30), 32'h7FFFFF));
    send_narrow(FMT_B64,  wide_word(FMT_B64, 1'b0, exp_for(FMT_B64, 1), 32'hFFFFF));
    // unnormal: integer bit clear
    send_narrow(FMT_X80,  wide_word(FMT_X80, 1'b0, exp_for(FMT_X80, 15), 32'h1234));
    send_narrow(FMT_B128, wide_word(FMT_B128, 1'b1, exp_for(FMT_B128, 0), 32'hFFFF));
    send_narrow(FMT_B32,  wide_word(FMT_B32, 1'b0, exp_for(FMT_B32, -10), 32'h7FFFFF));
    send_narrow(FMT_B64,  wide_word(FMT_B64, 1'b0, exp_for(FMT_B64, -11), 32'hFFFFF));
    send_narrow(FMT_X80,  wide_word(FMT_X80, 1'b1, exp_for(FMT_X80, -10), 32'hFFFF));
    send_narrow(FMT_B32,  wide_word(FMT_B32, 1'b0, exp_for(FMT_B32, 1), 32'd0));
    // widening corners
    send_widen(FMT_B32,  16'h0000);
    send_widen(FMT_X80,  16'h8000);
    send_widen(FMT_B64,  16'h0001);
    send_widen(FMT_X80,  16'h03FF);
    send_widen(FMT_B128, 16'h8200);
    send_widen(FMT_B32,  16'h7C00);
    send_widen(FMT_X80,  16'hFC00);
    send_widen(FMT_B64,  16'h7E01);
    send_widen(FMT_B128, 16'h7BFF);
    send_widen(FMT_X80,  16'h3C00);

    // random traffic under four idling mixes, draining between them
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 60; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 60; end
        default: begin src_idle_pct = 26; snk_stall_pct = 26; end
      endcase
      for (int i = 0; i < 150; i++) send(random_req());
      s_axis_tvalid <= 1'b0;
      drain();
    end

    snk_stall_pct = 0;
    repeat (10) @(posedge clk_i);
    if (sb.awaited.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.awaited.size()));
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/hpfc_pkg.sv
hdl/hpfc_core.sv
hdl/half_precision_format_converter_top.sv
dv/tb_half_precision_format_converter_top.sv
